// ===== src/grid_local_minimum_sum_macros.svh =====
// Assertion macros shared by the checkers of the grid local minimum block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef GRID_LOCAL_MINIMUM_SUM_MACROS_SVH
`define GRID_LOCAL_MINIMUM_SUM_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define GLMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid_local_minimum_sum: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define GLMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid_local_minimum_sum: next-cycle check failed");

`endif

// ===== src/glms_pkg.sv =====
// Package of the grid local minimum block: widths, codes and shared structs.
// No dependencies; imported by every file but the assertion macros header.
package glms_pkg;

    localparam int HEIGHT_W = 4;
    localparam int POS_W    = 7;
    localparam int RISK_W   = 18;
    localparam int CFG_W    = 8;
    localparam int RUN_MAX  = 3;
    localparam int COUNT_W  = 2;

    localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 8'd100;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 8'd100;

    typedef enum logic [0:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [HEIGHT_W-1:0] height_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [RISK_W-1:0]   risk_t;

    // One decision word as it leaves the block (last_of_run is added at the port)
    typedef struct packed {
        pos_t    cell_row;
        pos_t    cell_column;
        height_t cell_height;
        logic    is_minimum;
        risk_t   risk_total;
        logic    frame_done;
    } result_t;

    // Decisions caused by one input word, packed to the low slots
    typedef struct packed {
        logic [COUNT_W-1:0]        count;
        result_t [RUN_MAX-1:0]     slot;
    } run_t;

    // Position, flags and neighbor heights of the word under evaluation
    typedef struct packed {
        pos_t    row;
        pos_t    column;
        logic    last_column;
        logic    last_row;
        logic    column_gt0;
        logic    column_ge2;
        logic    row_gt0;
        logic    row_ge2;
        height_t value;
        height_t center;
        height_t right;
        height_t up;
        height_t left_above;
        height_t left_here;
        height_t left_here2;
    } eval_in_t;

endpackage

// ===== src/glms_if.sv =====
// Stream interfaces of the grid local minimum block: height input and decision output.
// Depends on glms_pkg.
interface glms_in_if import glms_pkg::*; ();
    logic    valid;
    logic    ready;
    height_t height_value;

    modport source (output valid, output height_value, input ready);
    modport sink (input valid, input height_value, output ready);
endinterface

interface glms_out_if import glms_pkg::*; ();
    logic    valid;
    logic    ready;
    pos_t    cell_row;
    pos_t    cell_column;
    height_t cell_height;
    logic    is_minimum;
    risk_t   risk_total;
    logic    frame_done;
    logic    last_of_run;

    modport source (
        output valid, output cell_row, output cell_column, output cell_height,
        output is_minimum, output risk_total, output frame_done, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input cell_row, input cell_column, input cell_height,
        input is_minimum, input risk_total, input frame_done, input last_of_run,
        output ready
    );
endinterface

// ===== src/glms_line_mem.sv =====
// Line buffer: one write port, one registered read port with write bypass.
// Depends on glms_pkg.
module glms_line_mem import glms_pkg::*; #(
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  height_t       wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output height_t       rdata
);

    height_t line_mem [DEPTH];
    height_t rdata_reg;

    // Write, and read with the same-cycle write forwarded
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            line_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= (we && (waddr == raddr)) ? wdata : line_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/glms_cell_eval.sv =====
// Decision logic: four-neighbor compares, risk sum chain and packing of the run.
// Depends on glms_pkg.
module glms_cell_eval import glms_pkg::*; (
    input  eval_in_t ein,
    input  risk_t    risk,
    output run_t     run,
    output risk_t    risk_next
);

    // Strictly below every neighbor that lies inside the grid
    function automatic logic lowest(
        input height_t c,
        input logic uv, input height_t u,
        input logic dv, input height_t d,
        input logic lv, input height_t l,
        input logic rv, input height_t r
    );
        lowest = !((uv && (c >= u)) || (dv && (c >= d)) ||
                   (lv && (c >= l)) || (rv && (c >= r)));
    endfunction

    logic    p0;
    logic    p1;
    logic    p2;
    logic    m0;
    logic    m1;
    logic    m2;
    risk_t   sum0;
    risk_t   sum1;
    risk_t   sum2;
    result_t r0;
    result_t r1;
    result_t r2;

    always_comb
    begin
        // Cell above the arriving word, then the final-row cells
        p0 = ein.row_gt0;
        p1 = ein.last_row && ein.column_gt0;
        p2 = ein.last_row && ein.last_column;

        m0 = lowest(ein.center, ein.row_ge2, ein.up, 1'b1, ein.value,
                    ein.column_gt0, ein.left_above, !ein.last_column, ein.right);
        m1 = lowest(ein.left_here, ein.row_gt0, ein.left_above, 1'b0, '0,
                    ein.column_ge2, ein.left_here2, 1'b1, ein.value);
        m2 = lowest(ein.value, ein.row_gt0, ein.center, 1'b0, '0,
                    ein.column_gt0, ein.left_here, 1'b0, '0);

        // Accumulate one plus height in raster order of the cells
        sum0 = risk + ((p0 && m0) ? (RISK_W'(ein.center) + RISK_W'(1)) : '0);
        sum1 = sum0 + ((p1 && m1) ? (RISK_W'(ein.left_here) + RISK_W'(1)) : '0);
        sum2 = sum1 + ((p2 && m2) ? (RISK_W'(ein.value) + RISK_W'(1)) : '0);

        r0.cell_row    = ein.row - POS_W'(1);
        r0.cell_column = ein.column;
        r0.cell_height = ein.center;
        r0.is_minimum  = m0;
        r0.risk_total  = sum0;
        r0.frame_done  = 1'b0;

        r1.cell_row    = ein.row;
        r1.cell_column = ein.column - POS_W'(1);
        r1.cell_height = ein.left_here;
        r1.is_minimum  = m1;
        r1.risk_total  = sum1;
        r1.frame_done  = 1'b0;

        r2.cell_row    = ein.row;
        r2.cell_column = ein.column;
        r2.cell_height = ein.value;
        r2.is_minimum  = m2;
        r2.risk_total  = sum2;
        r2.frame_done  = 1'b1;

        // Pack present decisions into the low slots
        run.slot[0] = p0 ? r0 : (p1 ? r1 : r2);
        run.slot[1] = (p0 && p1) ? r1 : r2;
        run.slot[2] = r2;
        run.count   = COUNT_W'({1'b0, p0}) + COUNT_W'({1'b0, p1}) + COUNT_W'({1'b0, p2});

        risk_next = sum2;
    end

endmodule

// ===== src/glms_run_buffer.sv =====
// Output register for the decisions of one input word, sent one word per cycle while the sink is ready.
// Depends on glms_pkg and glms_out_if.
module glms_run_buffer import glms_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  run_t         run_in,
    output logic         free,
    glms_out_if.source   decisions
);

    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    idx_reg;
    result_t [RUN_MAX-1:0] slot_reg;
    result_t               current;
    logic                  last;
    logic                  take;

    assign current = slot_reg[idx_reg];
    assign last    = (idx_reg == (count_reg - COUNT_W'(1)));
    assign take    = decisions.valid && decisions.ready;
    assign free    = (count_reg == '0) || (take && last);

    // Track how many words remain and which one is shown
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            count_reg <= run_in.count;
            idx_reg   <= '0;
        end
        else if (take && last)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + COUNT_W'(1);
        end
    end

    // Hold the payload of the run
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= run_in.slot;
        end
    end

    assign decisions.valid       = (count_reg != '0);
    assign decisions.cell_row    = current.cell_row;
    assign decisions.cell_column = current.cell_column;
    assign decisions.cell_height = current.cell_height;
    assign decisions.is_minimum  = current.is_minimum;
    assign decisions.risk_total  = current.risk_total;
    assign decisions.frame_done  = current.frame_done;
    assign decisions.last_of_run = last;

endmodule

// ===== src/grid_local_minimum_sum.sv =====
// Four-neighbor local minimum detector with running risk sum over a raster frame.
// Path: an accepted word waits in the evaluation stage register; its decisions then
// load into the output run buffer. Throughput: one word per cycle outside the final row
// while the output is ready; in the final row a word causes up to two decisions (three
// for the frame's last word), sent one per cycle while ready as the input is held.
// Reset: counters, sum and handshakes clear, config returns to 100 by 100; line buffers are not cleared.
module grid_local_minimum_sum import glms_pkg::*; #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    glms_in_if.sink          heights,
    glms_out_if.source       decisions,
    input  logic             cfg_we,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = (AW + 1 > CFG_W + 1) ? AW + 1 : CFG_W + 1;
    localparam int HW = (RW + 1 > CFG_W + 1) ? RW + 1 : CFG_W + 1;

    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [WW-1:0]    width_eff;
    logic [HW-1:0]    height_eff;
    logic [AW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic             last_col;
    logic             last_row;
    logic             accept;

    logic             s1_valid_reg;
    height_t          s1_value_reg;
    logic [AW-1:0]    s1_col_reg;
    logic [RW-1:0]    s1_row_reg;
    logic             s1_last_col_reg;
    logic             s1_last_row_reg;
    logic             s1_fire;

    height_t          center;
    height_t          right;
    height_t          up;
    height_t          left_above_reg;
    height_t          left_here_reg;
    height_t          left_here2_reg;
    risk_t            risk_reg;
    risk_t            risk_next;

    eval_in_t         ein;
    run_t             run;
    logic             run_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= GRID_WIDTH_RESET;
            height_cfg_reg <= GRID_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  width_cfg_reg  <= cfg_data;
                REG_GRID_HEIGHT: height_cfg_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Clamp the frame size into one to the maximum
    always_comb
    begin
        if (width_cfg_reg == '0)
            width_eff = WW'(1);
        else if (WW'(width_cfg_reg) > WW'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(width_cfg_reg);

        if (height_cfg_reg == '0)
            height_eff = HW'(1);
        else if (HW'(height_cfg_reg) > HW'(MAX_HEIGHT))
            height_eff = HW'(MAX_HEIGHT);
        else
            height_eff = HW'(height_cfg_reg);
    end

    assign last_col = (WW'(col_reg) + WW'(1)) >= width_eff;
    assign last_row = (HW'(row_reg) + HW'(1)) >= height_eff;

    // Accept a word when the evaluation stage is empty or moving on
    assign heights.ready = !s1_valid_reg || s1_fire;
    assign accept        = heights.valid && heights.ready;
    assign s1_fire       = s1_valid_reg && ((run.count == '0) || run_free);

    // Advance the raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : (row_reg + RW'(1));
            end
            else
            begin
                col_reg <= col_reg + AW'(1);
            end
        end
    end

    // Evaluation stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg    <= heights.height_value;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

    // Line buffers: this row at the column and the one right of it, the row before
    glms_line_mem #(.DEPTH(MAX_WIDTH)) u_prev_here (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (s1_value_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (center)
    );

    glms_line_mem #(.DEPTH(MAX_WIDTH)) u_prev_next (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (s1_value_reg),
        .re    (accept),
        .raddr (col_reg + AW'(1)),
        .rdata (right)
    );

    glms_line_mem #(.DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_col_reg),
        .wdata (center),
        .re    (accept),
        .raddr (col_reg),
        .rdata (up)
    );

    // Left neighbors kept in registers, advanced once per evaluated word
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            left_above_reg <= center;
            left_here2_reg <= left_here_reg;
            left_here_reg  <= s1_value_reg;
        end
    end

    // Running sum, dropped after the frame's last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            risk_reg <= '0;
        end
        else if (s1_fire)
        begin
            risk_reg <= (s1_last_col_reg && s1_last_row_reg) ? '0 : risk_next;
        end
    end

    always_comb
    begin
        ein.row         = POS_W'(s1_row_reg);
        ein.column      = POS_W'(s1_col_reg);
        ein.last_column = s1_last_col_reg;
        ein.last_row    = s1_last_row_reg;
        ein.column_gt0  = (s1_col_reg != '0);
        ein.column_ge2  = (s1_col_reg > AW'(1));
        ein.row_gt0     = (s1_row_reg != '0);
        ein.row_ge2     = (s1_row_reg > RW'(1));
        ein.value       = s1_value_reg;
        ein.center      = center;
        ein.right       = right;
        ein.up          = up;
        ein.left_above  = left_above_reg;
        ein.left_here   = left_here_reg;
        ein.left_here2  = left_here2_reg;
    end

    glms_cell_eval u_eval (
        .ein       (ein),
        .risk      (risk_reg),
        .run       (run),
        .risk_next (risk_next)
    );

    glms_run_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_fire && (run.count != '0)),
        .run_in    (run),
        .free      (run_free),
        .decisions (decisions)
    );

endmodule

// ===== src/glms_checker.sv =====
// Port-level checks of the decision stream, bound to the top level.
// Depends on grid_local_minimum_sum_macros.svh and glms_pkg.
`include "grid_local_minimum_sum_macros.svh"

module glms_checker import glms_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    out_valid,
    input logic    out_ready,
    input pos_t    cell_row,
    input pos_t    cell_column,
    input height_t cell_height,
    input logic    is_minimum,
    input risk_t   risk_total,
    input logic    frame_done,
    input logic    last_of_run
);

    logic       out_take;
    logic       out_stall;
    result_t    payload;

    assign out_take  = out_valid && out_ready;
    assign out_stall = out_valid && !out_ready;

    assign payload.cell_row    = cell_row;
    assign payload.cell_column = cell_column;
    assign payload.cell_height = cell_height;
    assign payload.is_minimum  = is_minimum;
    assign payload.risk_total  = risk_total;
    assign payload.frame_done  = frame_done;

    // A stalled word stays offered and unchanged
    `GLMS_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_stall, out_valid)
    `GLMS_ASSERT_NEXT(a_hold_word, clk, rst_n, out_stall, $stable(payload) && $stable(last_of_run))

    // The frame's final decision closes the run of its input word
    `GLMS_ASSERT_SAME(a_done_last, clk, rst_n, out_valid && frame_done, last_of_run)

    // Within a frame the sum never falls between back-to-back words
    `GLMS_ASSERT_NEXT(a_sum_rises, clk, rst_n, out_take && !frame_done, !out_take || (risk_total >= $past(risk_total)))

endmodule

bind grid_local_minimum_sum glms_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (decisions.valid),
    .out_ready   (decisions.ready),
    .cell_row    (decisions.cell_row),
    .cell_column (decisions.cell_column),
    .cell_height (decisions.cell_height),
    .is_minimum  (decisions.is_minimum),
    .risk_total  (decisions.risk_total),
    .frame_done  (decisions.frame_done),
    .last_of_run (decisions.last_of_run)
);

// ===== tb/grid_local_minimum_sum_test.sv =====
// Self-checking testbench for grid_local_minimum_sum: streams raster frames of heights
// and checks every decision word against an in-bench predictor of the detector.
// Depends on glms_pkg, glms_in_if, glms_out_if and the grid_local_minimum_sum RTL.
module grid_local_minimum_sum_test;
    import glms_pkg::*;

    localparam int GRID_MAX      = 128;
    localparam int STALL_LIMIT   = 400;
    localparam int RANDOM_WORDS  = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_LIMIT   = 40;

    // One expected decision word, port flag included
    typedef struct packed {
        result_t body;
        logic    last_of_run;
    } decision_word_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    glms_in_if  heights_ch ();
    glms_out_if decisions_ch ();

    grid_local_minimum_sum dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .heights   (heights_ch),
        .decisions (decisions_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: size registers, line buffers, raster position and running sum
    logic [CFG_W-1:0] width_reg  = GRID_WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = GRID_HEIGHT_RESET;
    height_t          older_row [GRID_MAX];
    height_t          prior_row [GRID_MAX];
    int unsigned      col_pos    = 0;
    int unsigned      row_pos    = 0;
    risk_t            risk_acc   = '0;
    height_t          left_above = '0;
    decision_word_t   pending_decisions [$];

    // Run statistics and flags
    int unsigned words_sent     = 0;
    int unsigned decisions_seen = 0;
    int unsigned minima_seen    = 0;
    int unsigned frames_done    = 0;
    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned sender_calm    = 0;
    bit          idle_on        = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Register values of zero act as one, values above the maximum act as the maximum
    function automatic int unsigned effective_size(input logic [CFG_W-1:0] value);
        if (value == '0)
            return 1;
        if (value > GRID_MAX)
            return GRID_MAX;
        return value;
    endfunction

    // Strict compare against every neighbor that lies inside the grid
    function automatic bit strictly_lowest(input height_t mid,
                                           input bit up_in, input height_t up,
                                           input bit down_in, input height_t down,
                                           input bit left_in, input height_t left,
                                           input bit right_in, input height_t right);
        if (up_in && !(mid < up))
            return 1'b0;
        if (down_in && !(mid < down))
            return 1'b0;
        if (left_in && !(mid < left))
            return 1'b0;
        if (right_in && !(mid < right))
            return 1'b0;
        return 1'b1;
    endfunction

    // Add one decision to the expected stream, updating the running sum
    task automatic log_decision(input int unsigned row, input int unsigned col,
                                input height_t level, input bit low, input bit done);
        decision_word_t word;
        if (low)
            risk_acc = risk_acc + risk_t'(level) + risk_t'(1);
        word.body.cell_row    = pos_t'(row);
        word.body.cell_column = pos_t'(col);
        word.body.cell_height = level;
        word.body.is_minimum  = low;
        word.body.risk_total  = risk_acc;
        word.body.frame_done  = done;
        word.last_of_run      = 1'b0;
        pending_decisions = {pending_decisions, word};
    endtask

    // Work out the decisions that one accepted height word causes
    task automatic predict_decisions(input height_t value);
        int unsigned    cols;
        int unsigned    rows;
        int unsigned    c;
        int unsigned    r;
        int unsigned    produced;
        bit             end_col;
        bit             end_row;
        bit             low;
        height_t        center;
        height_t        right;
        height_t        left2;
        decision_word_t word;
        cols     = effective_size(width_reg);
        rows     = effective_size(height_reg);
        c        = col_pos;
        r        = row_pos;
        produced = 0;
        end_col  = (c + 1 >= cols);
        end_row  = (r + 1 >= rows);

        // Decide the cell above the arriving word
        center = prior_row[c];
        if (r > 0)
        begin
            right = end_col ? height_t'(0) : prior_row[c + 1];
            low = strictly_lowest(center, r >= 2, older_row[c], 1'b1, value,
                                  c > 0, left_above, !end_col, right);
            log_decision(r - 1, c, center, low, 1'b0);
            produced++;
        end

        // Shift the column down the line buffers
        left_above   = center;
        older_row[c] = center;
        prior_row[c] = value;

        // Final row: decide the left cell, and the last cell on the last column
        if (end_row)
        begin
            if (c > 0)
            begin
                left2 = (c > 1) ? prior_row[c - 2] : height_t'(0);
                low = strictly_lowest(prior_row[c - 1], r > 0, older_row[c - 1],
                                      1'b0, height_t'(0), c > 1, left2, 1'b1, value);
                log_decision(r, c - 1, prior_row[c - 1], low, 1'b0);
                produced++;
            end
            if (end_col)
            begin
                left2 = (c > 0) ? prior_row[c - 1] : height_t'(0);
                low = strictly_lowest(value, r > 0, older_row[c], 1'b0, height_t'(0),
                                      c > 0, left2, 1'b0, height_t'(0));
                log_decision(r, c, value, low, 1'b1);
                produced++;
            end
        end

        // Flag the final decision of this word
        if (produced > 0)
        begin
            word = pending_decisions.pop_back();
            word.last_of_run = 1'b1;
            pending_decisions = {pending_decisions, word};
        end

        // Advance the raster position; restart counters and sum at frame end
        if (end_col)
        begin
            col_pos = 0;
            if (end_row)
            begin
                row_pos  = 0;
                risk_acc = '0;
            end
            else
                row_pos = r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: decision %0d: %s got %0d, expected %0d",
                     $time, decisions_seen, what, got, want);
    endtask

    // Send one height word, with an occasional idle burst ahead of it
    task automatic send_height(input height_t value);
        if (sender_calm > 0)
            sender_calm--;
        else if ($urandom_range(0, 24) == 0)
            sender_calm = $urandom_range(20, 60);
        if (idle_on && sender_calm == 0 && $urandom_range(0, 7) == 0)
        begin
            heights_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        heights_ch.valid        <= 1'b1;
        heights_ch.height_value <= value;
        @(posedge clk);
        while (heights_ch.ready !== 1'b1)
            @(posedge clk);
        predict_decisions(value);
        words_sent++;
    endtask

    // Drop valid and wait until every expected decision has come out
    task automatic settle();
        heights_ch.valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both size registers while the block is idle
    task automatic set_frame_size(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data  <= cols;
        @(posedge clk);
        width_reg  = cols;
        cfg_index <= REG_GRID_HEIGHT;
        cfg_data  <= rows;
        @(posedge clk);
        height_reg = rows;
        cfg_we    <= 1'b0;
    endtask

    function automatic height_t random_height(input bit narrow);
        if (narrow)
            return height_t'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 12)
            return height_t'($urandom_range(10, 15));
        return height_t'($urandom_range(0, 9));
    endfunction

    task automatic run_listed_frame(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows,
                                    input height_t cells [$]);
        set_frame_size(cols, rows);
        foreach (cells[i])
            send_height(cells[i]);
    endtask

    task automatic run_random_frame(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
        int unsigned count;
        bit          narrow;
        count  = effective_size(cols) * effective_size(rows);
        narrow = ($urandom_range(0, 3) == 0);
        set_frame_size(cols, rows);
        repeat (count) send_height(random_height(narrow));
    endtask

    // One-cell frames: zero register values act as one, lowest and highest heights
    task automatic test_single_cell();
        run_listed_frame(8'd0, 8'd0, '{4'd15});
        run_listed_frame(8'd1, 8'd1, '{4'd0});
    endtask

    // Small grid with ties in both directions and heights above nine
    task automatic test_three_by_three();
        run_listed_frame(8'd3, 8'd3, '{4'd5, 4'd1, 4'd5, 4'd9, 4'd9, 4'd0, 4'd9, 4'd12, 4'd0});
    endtask

    // Degenerate shapes: one column, then one row
    task automatic test_thin_frames();
        run_listed_frame(8'd1, 8'd4, '{4'd3, 4'd2, 4'd2, 4'd7});
        run_listed_frame(8'd5, 8'd1, '{4'd4, 4'd2, 4'd6, 4'd0, 4'd9});
    endtask

    // Two frames back to back: counters and sum restart without a register write
    task automatic test_frame_restart();
        run_listed_frame(8'd2, 8'd2, '{4'd1, 4'd2, 4'd3, 4'd4, 4'd8, 4'd0, 4'd0, 4'd8});
    endtask

    // Full-size rows and columns, including register values above the maximum
    task automatic test_size_extremes();
        run_random_frame(8'd255, 8'd1);
        run_random_frame(8'd1, 8'd200);
    endtask

    // Random frames, mostly small, until enough words went through
    task automatic test_random_frames();
        int unsigned      start;
        int unsigned      roll;
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rows;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                cols = '0;
            else if (roll < 15)
                cols = CFG_W'($urandom_range(1, 8));
            else
                cols = CFG_W'($urandom_range(9, 32));
            roll = $urandom_range(0, 19);
            if (roll == 0)
                rows = '0;
            else if (roll < 15)
                rows = CFG_W'($urandom_range(1, 6));
            else
                rows = CFG_W'($urandom_range(7, 12));
            run_random_frame(cols, rows);
        end
    endtask

    // Closing frames at full rate on both sides
    task automatic test_full_rate();
        idle_on = 1'b0;
        run_random_frame(8'd4, 8'd3);
        run_random_frame(8'd7, 8'd5);
        run_random_frame(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(1, 6)));
    endtask

    // Drive ready with random stall bursts and calm stretches
    initial
    begin : drive_ready
        int unsigned stall_left;
        int unsigned calm_left;
        int unsigned roll;
        stall_left = 0;
        calm_left  = 0;
        decisions_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            roll = $urandom_range(0, 39);
            if (!idle_on)
                decisions_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                decisions_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (calm_left > 0)
            begin
                decisions_ch.ready <= 1'b1;
                calm_left--;
            end
            else if (roll < 3)
            begin
                decisions_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 18);
            end
            else
            begin
                decisions_ch.ready <= 1'b1;
                if (roll == 3)
                    calm_left = $urandom_range(30, 90);
            end
        end
    end

    // Compare each accepted decision word with the oldest expectation
    always @(posedge clk)
    begin : check_decisions
        decision_word_t want;
        if (rst_n === 1'b1 && decisions_ch.valid === 1'b1 && decisions_ch.ready === 1'b1)
        begin
            decisions_seen++;
            if (pending_decisions.size() == 0)
                report_mismatch("unexpected word, cell_row", decisions_ch.cell_row, 0);
            else
            begin
                want = pending_decisions.pop_front();
                if (decisions_ch.cell_row !== want.body.cell_row)
                    report_mismatch("cell_row", decisions_ch.cell_row, want.body.cell_row);
                if (decisions_ch.cell_column !== want.body.cell_column)
                    report_mismatch("cell_column", decisions_ch.cell_column,
                                    want.body.cell_column);
                if (decisions_ch.cell_height !== want.body.cell_height)
                    report_mismatch("cell_height", decisions_ch.cell_height,
                                    want.body.cell_height);
                if (decisions_ch.is_minimum !== want.body.is_minimum)
                    report_mismatch("is_minimum", decisions_ch.is_minimum,
                                    want.body.is_minimum);
                if (decisions_ch.risk_total !== want.body.risk_total)
                    report_mismatch("risk_total", decisions_ch.risk_total,
                                    want.body.risk_total);
                if (decisions_ch.frame_done !== want.body.frame_done)
                    report_mismatch("frame_done", decisions_ch.frame_done,
                                    want.body.frame_done);
                if (decisions_ch.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", decisions_ch.last_of_run,
                                    want.last_of_run);
                if (want.body.is_minimum)
                    minima_seen++;
                if (want.body.frame_done)
                    frames_done++;
            end
        end
    end

    // Stop the run when neither side has moved a word for too long
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (heights_ch.valid === 1'b1 && heights_ch.ready === 1'b1) ||
            (decisions_ch.valid === 1'b1 && decisions_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles, %0d decisions still expected",
                     $time, STALL_LIMIT, pending_decisions.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : run_tests
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= REG_GRID_WIDTH;
        cfg_data                <= '0;
        heights_ch.valid        <= 1'b0;
        heights_ch.height_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_cell();
        test_three_by_three();
        test_thin_frames();
        test_frame_restart();
        test_size_extremes();
        test_random_frames();
        test_full_rate();
        settle();

        $display("Sent %0d height words over %0d frames, sizes 1x1 up to 128 wide and tall.",
                 words_sent, frames_done);
        $display("Checked %0d decision words, %0d of them minima; %0d mismatches.",
                 decisions_seen, minima_seen, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== grid_local_minimum_sum.f =====
+incdir+src
src/glms_pkg.sv
src/glms_if.sv
src/glms_line_mem.sv
src/glms_cell_eval.sv
src/glms_run_buffer.sv
src/grid_local_minimum_sum.sv
src/glms_checker.sv
tb/grid_local_minimum_sum_test.sv
